>>> hw/rtl/plni_pkg.sv
package plni_pkg;

   // Widths fixed by the register map and the request fields.
   localparam int DIR_BITS      = 3;
   localparam int DIMS_BITS     = 3;
   localparam int LEN_BITS      = 17;
   localparam int NUM_LEN_REGS  = 4;
   localparam int DIM_BITS      = 2;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   // Register indexes, one word apart on the configuration port.
   localparam logic [REG_IDX_BITS-1:0] REG_NUM_DIMS    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_LENGTH_DIM0 = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_LENGTH_DIM1 = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_LENGTH_DIM2 = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_LENGTH_DIM3 = 3'd4;

   // Control that travels with each transaction down the pipeline.
   typedef struct packed {
      logic                valid;
      logic                bad;
      logic                fwd;
      logic [DIM_BITS-1:0] dim;
   } ctl_type;

endpackage

>>> hw/rtl/periodic_lattice_neighbour_index.sv
// Nearest-neighbour lookup on a periodic rectangular lattice.
//
// A request transaction carries a site index and a direction; each request
// produces exactly one response transaction with the neighbouring site and
// a flag for a bad request (neighbour zero in that case). Lattice shape is
// to be set by the user through the APB-style register port only while no
// request is in flight; the block itself does not enforce this.
//
// The pipeline is a row of cells: a decode stage, one product cell per
// dimension (at most four) that builds the lattice size and the stride, a
// bounds stage, one restoring-division cell per site bit for the site
// modulo the block span, a wrap stage and the output register. One
// request is accepted every cycle while req_stall is low.
//
// When the receiver stalls, one further response is caught in a skid
// register and the pipeline then holds; req_stall is that register's
// state. Reset empties the pipeline and sets one dimension of length one.
module periodic_lattice_neighbour_index import plni_pkg::*; #(
   parameter int MAX_DIMS  = 4,
   parameter int SITE_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SITE_BITS-1:0]     req_site_index,
   input  logic [DIR_BITS-1:0]      req_direction,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SITE_BITS-1:0]     rsp_neighbour_site,
   output logic                     rsp_bad_request,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int NUM_CELLS = (MAX_DIMS < NUM_LEN_REGS) ? MAX_DIMS : NUM_LEN_REGS;

   // Configuration registers.
   logic [DIMS_BITS-1:0] num_dims_ff, num_dims_in;
   logic [LEN_BITS-1:0]  len_ff [NUM_LEN_REGS];
   logic [LEN_BITS-1:0]  len_in [NUM_LEN_REGS];
   logic [REG_IDX_BITS-1:0] csr_idx;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      num_dims_in = num_dims_ff;
      len_in      = len_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_NUM_DIMS:    num_dims_in = csr_pwdata[DIMS_BITS-1:0];
            REG_LENGTH_DIM0: len_in[0]   = csr_pwdata[LEN_BITS-1:0];
            REG_LENGTH_DIM1: len_in[1]   = csr_pwdata[LEN_BITS-1:0];
            REG_LENGTH_DIM2: len_in[2]   = csr_pwdata[LEN_BITS-1:0];
            REG_LENGTH_DIM3: len_in[3]   = csr_pwdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= DIMS_BITS'(1);
         for (int i = 0; i < NUM_LEN_REGS; i++) begin
            len_ff[i] <= LEN_BITS'(1);
         end
      end else begin
         num_dims_ff <= num_dims_in;
         len_ff      <= len_in;
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_idx)
         REG_NUM_DIMS:    csr_prdata = CSR_DATA_BITS'(num_dims_ff);
         REG_LENGTH_DIM0: csr_prdata = CSR_DATA_BITS'(len_ff[0]);
         REG_LENGTH_DIM1: csr_prdata = CSR_DATA_BITS'(len_ff[1]);
         REG_LENGTH_DIM2: csr_prdata = CSR_DATA_BITS'(len_ff[2]);
         REG_LENGTH_DIM3: csr_prdata = CSR_DATA_BITS'(len_ff[3]);
         default:         csr_prdata = '0;
      endcase
   end

   // Effective dimension count, clamped to one up to the number of cells.
   logic [DIMS_BITS-1:0] dims_eff;

   always_comb begin
      priority if (num_dims_ff == '0) begin
         dims_eff = DIMS_BITS'(1);
      end else if (num_dims_ff > DIMS_BITS'(NUM_CELLS)) begin
         dims_eff = DIMS_BITS'(NUM_CELLS);
      end else begin
         dims_eff = num_dims_ff;
      end
   end

   // The whole pipeline moves whenever the skid register is empty.
   logic skid_valid_ff, skid_valid_in;
   logic advance;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Decode stage: direction into dimension, sense and range check.
   ctl_type              dec_ctl_ff, dec_ctl_in;
   logic [SITE_BITS-1:0] dec_site_ff;
   logic [DIR_BITS-1:0]  dim_full;
   logic                 dir_fwd;
   logic                 dir_bad;

   assign dir_fwd  = (req_direction < DIR_BITS'(dims_eff));
   assign dir_bad  = ({1'b0, req_direction} >= {1'b0, dims_eff, 1'b0});
   assign dim_full = dir_fwd ? req_direction : (req_direction - DIR_BITS'(dims_eff));

   always_comb begin
      dec_ctl_in.valid = req_valid;
      dec_ctl_in.bad   = dir_bad;
      dec_ctl_in.fwd   = dir_fwd;
      dec_ctl_in.dim   = dim_full[DIM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ctl_ff <= '0;
      end else if (advance) begin
         dec_ctl_ff <= dec_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_site_ff <= req_site_index;
      end
   end

   // Product cells, one per dimension.
   ctl_type              p_ctl    [NUM_CELLS+1];
   logic [SITE_BITS-1:0] p_site   [NUM_CELLS+1];
   logic [SITE_BITS:0]   p_prod   [NUM_CELLS+1];
   logic [SITE_BITS:0]   p_stride [NUM_CELLS+1];
   logic [SITE_BITS:0]   p_block  [NUM_CELLS+1];

   assign p_ctl[0]    = dec_ctl_ff;
   assign p_site[0]   = dec_site_ff;
   assign p_prod[0]   = (SITE_BITS+1)'(1);
   assign p_stride[0] = '0;
   assign p_block[0]  = '0;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_prod
      plni_prod_cell #(
         .SITE_BITS (SITE_BITS),
         .CELL_IDX  (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .dims_eff   (dims_eff),
         .length     (len_ff[k]),
         .ctl_in     (p_ctl[k]),
         .site_in    (p_site[k]),
         .prod_in    (p_prod[k]),
         .stride_in  (p_stride[k]),
         .block_in   (p_block[k]),
         .ctl_out    (p_ctl[k+1]),
         .site_out   (p_site[k+1]),
         .prod_out   (p_prod[k+1]),
         .stride_out (p_stride[k+1]),
         .block_out  (p_block[k+1])
      );
   end

   // Bounds stage: site against lattice size, and the wrap distance.
   ctl_type              prep_ctl_ff, prep_ctl_in;
   logic [SITE_BITS-1:0] prep_site_ff;
   logic [SITE_BITS:0]   prep_divisor_ff;
   logic [SITE_BITS:0]   prep_stride_ff;
   logic [SITE_BITS:0]   prep_span_ff;

   always_comb begin
      prep_ctl_in = p_ctl[NUM_CELLS];
      if ({1'b0, p_site[NUM_CELLS]} >= p_prod[NUM_CELLS]) begin
         prep_ctl_in.bad = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctl_ff <= '0;
      end else if (advance) begin
         prep_ctl_ff <= prep_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_site_ff    <= p_site[NUM_CELLS];
         prep_divisor_ff <= p_block[NUM_CELLS];
         prep_stride_ff  <= p_stride[NUM_CELLS];
         prep_span_ff    <= p_block[NUM_CELLS] - p_stride[NUM_CELLS];
      end
   end

   // Division cells: site modulo the block span, most significant bit first.
   ctl_type              d_ctl     [SITE_BITS+1];
   logic [SITE_BITS-1:0] d_site    [SITE_BITS+1];
   logic [SITE_BITS-1:0] d_rem     [SITE_BITS+1];
   logic [SITE_BITS:0]   d_divisor [SITE_BITS+1];
   logic [SITE_BITS:0]   d_stride  [SITE_BITS+1];
   logic [SITE_BITS:0]   d_span    [SITE_BITS+1];

   assign d_ctl[0]     = prep_ctl_ff;
   assign d_site[0]    = prep_site_ff;
   assign d_rem[0]     = '0;
   assign d_divisor[0] = prep_divisor_ff;
   assign d_stride[0]  = prep_stride_ff;
   assign d_span[0]    = prep_span_ff;

   for (genvar j = 0; j < SITE_BITS; j++) begin : g_div
      plni_div_cell #(
         .SITE_BITS (SITE_BITS),
         .BIT_IDX   (SITE_BITS - 1 - j)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .ctl_in      (d_ctl[j]),
         .site_in     (d_site[j]),
         .rem_in      (d_rem[j]),
         .divisor_in  (d_divisor[j]),
         .stride_in   (d_stride[j]),
         .span_in     (d_span[j]),
         .ctl_out     (d_ctl[j+1]),
         .site_out    (d_site[j+1]),
         .rem_out     (d_rem[j+1]),
         .divisor_out (d_divisor[j+1]),
         .stride_out  (d_stride[j+1]),
         .span_out    (d_span[j+1])
      );
   end

   // Wrap stage: decide whether the step crosses the edge and which
   // offset to apply.
   ctl_type              wrap_ctl_ff;
   logic [SITE_BITS-1:0] wrap_site_ff;
   logic [SITE_BITS:0]   wrap_delta_ff, wrap_delta_in;
   logic                 wrap_sub_ff, wrap_sub_in;
   logic                 wraps;
   ctl_type              last_ctl;

   assign last_ctl = d_ctl[SITE_BITS];

   always_comb begin
      if (last_ctl.fwd) begin
         wraps = ({1'b0, d_rem[SITE_BITS]} >= d_span[SITE_BITS]);
      end else begin
         wraps = ({1'b0, d_rem[SITE_BITS]} < d_stride[SITE_BITS]);
      end
      wrap_delta_in = wraps ? d_span[SITE_BITS] : d_stride[SITE_BITS];
      wrap_sub_in   = last_ctl.fwd ? wraps : !wraps;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ctl_ff <= '0;
      end else if (advance) begin
         wrap_ctl_ff <= last_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wrap_site_ff  <= d_site[SITE_BITS];
         wrap_delta_ff <= wrap_delta_in;
         wrap_sub_ff   <= wrap_sub_in;
      end
   end

   // Final offset applied on the way into the output register.
   logic [SITE_BITS:0]   sum;
   logic [SITE_BITS-1:0] new_site;

   always_comb begin
      if (wrap_sub_ff) begin
         sum = {1'b0, wrap_site_ff} - wrap_delta_ff;
      end else begin
         sum = {1'b0, wrap_site_ff} + wrap_delta_ff;
      end
      new_site = wrap_ctl_ff.bad ? '0 : sum[SITE_BITS-1:0];
   end

   // Output register and skid register.
   logic                 out_valid_ff, out_valid_in;
   logic [SITE_BITS-1:0] out_site_ff, out_site_in;
   logic                 out_bad_ff, out_bad_in;
   logic [SITE_BITS-1:0] skid_site_ff, skid_site_in;
   logic                 skid_bad_ff, skid_bad_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_site_in   = out_site_ff;
      out_bad_in    = out_bad_ff;
      skid_valid_in = skid_valid_ff;
      skid_site_in  = skid_site_ff;
      skid_bad_in   = skid_bad_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_valid_in  = 1'b1;
            out_site_in   = skid_site_ff;
            out_bad_in    = skid_bad_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = wrap_ctl_ff.valid;
         out_site_in  = new_site;
         out_bad_in   = wrap_ctl_ff.bad;
      end else if (wrap_ctl_ff.valid) begin
         skid_valid_in = 1'b1;
         skid_site_in  = new_site;
         skid_bad_in   = wrap_ctl_ff.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_site_ff  <= out_site_in;
      out_bad_ff   <= out_bad_in;
      skid_site_ff <= skid_site_in;
      skid_bad_ff  <= skid_bad_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_neighbour_site = out_site_ff;
   assign rsp_bad_request    = out_bad_ff;

endmodule

>>> hw/rtl/plni_prod_cell.sv
module plni_prod_cell import plni_pkg::*; #(
   parameter int SITE_BITS = 20,
   parameter int CELL_IDX  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [DIMS_BITS-1:0] dims_eff,
   input  logic [LEN_BITS-1:0]  length,
   input  ctl_type              ctl_in,
   input  logic [SITE_BITS-1:0] site_in,
   input  logic [SITE_BITS:0]   prod_in,
   input  logic [SITE_BITS:0]   stride_in,
   input  logic [SITE_BITS:0]   block_in,
   output ctl_type              ctl_out,
   output logic [SITE_BITS-1:0] site_out,
   output logic [SITE_BITS:0]   prod_out,
   output logic [SITE_BITS:0]   stride_out,
   output logic [SITE_BITS:0]   block_out
);

   localparam int PROD_W = SITE_BITS + 1 + LEN_BITS;
   localparam logic [PROD_W-1:0] CAP_WIDE = PROD_W'(1) << SITE_BITS;

   ctl_type              ctl_ff, ctl_in_next;
   logic [SITE_BITS-1:0] site_ff;
   logic [SITE_BITS:0]   prod_ff, prod_in_next;
   logic [SITE_BITS:0]   stride_ff, stride_in_next;
   logic [SITE_BITS:0]   block_ff, block_in_next;
   logic [LEN_BITS-1:0]  len_eff;
   logic [PROD_W-1:0]    prod_full;
   logic                 used;

   // A zero length counts as one.
   assign len_eff   = (length == '0) ? LEN_BITS'(1) : length;
   assign prod_full = PROD_W'(prod_in) * PROD_W'(len_eff);
   assign used      = (DIMS_BITS'(CELL_IDX) < dims_eff);

   // Extend the running lattice size by this dimension and pick off the
   // stride and the block span when this is the dimension being stepped.
   always_comb begin
      ctl_in_next    = ctl_in;
      prod_in_next   = prod_in;
      stride_in_next = stride_in;
      block_in_next  = block_in;
      if (used) begin
         prod_in_next = prod_full[SITE_BITS:0];
         if (prod_full > CAP_WIDE) begin
            ctl_in_next.bad = 1'b1;
         end
      end
      if (ctl_in.dim == DIM_BITS'(CELL_IDX)) begin
         stride_in_next = prod_in;
         block_in_next  = prod_full[SITE_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         site_ff   <= site_in;
         prod_ff   <= prod_in_next;
         stride_ff <= stride_in_next;
         block_ff  <= block_in_next;
      end
   end

   assign ctl_out    = ctl_ff;
   assign site_out   = site_ff;
   assign prod_out   = prod_ff;
   assign stride_out = stride_ff;
   assign block_out  = block_ff;

endmodule

>>> hw/rtl/plni_div_cell.sv
module plni_div_cell import plni_pkg::*; #(
   parameter int SITE_BITS = 20,
   parameter int BIT_IDX   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ctl_type              ctl_in,
   input  logic [SITE_BITS-1:0] site_in,
   input  logic [SITE_BITS-1:0] rem_in,
   input  logic [SITE_BITS:0]   divisor_in,
   input  logic [SITE_BITS:0]   stride_in,
   input  logic [SITE_BITS:0]   span_in,
   output ctl_type              ctl_out,
   output logic [SITE_BITS-1:0] site_out,
   output logic [SITE_BITS-1:0] rem_out,
   output logic [SITE_BITS:0]   divisor_out,
   output logic [SITE_BITS:0]   stride_out,
   output logic [SITE_BITS:0]   span_out
);

   ctl_type              ctl_ff;
   logic [SITE_BITS-1:0] site_ff;
   logic [SITE_BITS-1:0] rem_ff, rem_in_next;
   logic [SITE_BITS:0]   divisor_ff;
   logic [SITE_BITS:0]   stride_ff;
   logic [SITE_BITS:0]   span_ff;
   logic [SITE_BITS:0]   trial;
   logic [SITE_BITS:0]   diff;

   // One restoring step: shift in the next site bit and subtract the
   // divisor when it fits. The remainder always stays below the divisor.
   assign trial = {rem_in, site_in[BIT_IDX]};
   assign diff  = trial - divisor_in;

   always_comb begin
      if (trial >= divisor_in) begin
         rem_in_next = diff[SITE_BITS-1:0];
      end else begin
         rem_in_next = trial[SITE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         site_ff    <= site_in;
         rem_ff     <= rem_in_next;
         divisor_ff <= divisor_in;
         stride_ff  <= stride_in;
         span_ff    <= span_in;
      end
   end

   assign ctl_out     = ctl_ff;
   assign site_out    = site_ff;
   assign rem_out     = rem_ff;
   assign divisor_out = divisor_ff;
   assign stride_out  = stride_ff;
   assign span_out    = span_ff;

endmodule

>>> hw/rtl/plni_checker.sv
module plni_checker #(
   parameter int SITE_BITS = 20
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [SITE_BITS-1:0] rsp_neighbour_site,
   input logic                 rsp_bad_request
);

   // A rejected request always reports neighbour zero.
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_request |-> rsp_neighbour_site == '0)
      else $error("bad request with a non-zero neighbour");

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_neighbour_site)
                                 && $stable(rsp_bad_request))
      else $error("stalled response changed");

   // Reset empties the output and opens the request side.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or stall not cleared by reset");

   // Request stall only follows a stalled response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a stalled response");

   // Once the receiver takes the response, the request side reopens.
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> !req_stall)
      else $error("request stall held after the receiver took the response");

endmodule

bind periodic_lattice_neighbour_index plni_checker #(
   .SITE_BITS (SITE_BITS)
) u_plni_checker (.*);
